FILE: src/esc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and tables for the epoch seconds to calendar block.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned SecWidth   = 31;
  localparam int unsigned DqWidth    = 32;  // dividend register
  localparam int unsigned DivSteps   = 2;   // multiply step, then remainder step
  localparam int unsigned StepWidth  = $clog2(DivSteps);
  localparam int unsigned DaysWidth  = 15;

  localparam logic [10:0] EpochYear    = 11'd1970;
  localparam logic [6:0]  EpochMod100  = 7'd70;
  localparam logic [8:0]  EpochMod400  = 9'd370;
  localparam logic [2:0]  EpochWeekday = 3'd4;
  localparam logic [3:0]  MonthFeb     = 4'd1;
  localparam logic [3:0]  MonthDec     = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH
  } state_t;

  // Divider passes, in the order the controller runs them.
  typedef enum logic [1:0] {
    PASS_SEC,
    PASS_MIN,
    PASS_HOUR,
    PASS_WDAY
  } pass_t;

  typedef struct packed {
    logic  load;
    logic  div_en;
    logic  div_first;
    logic  div_last;
    pass_t pass;
    logic  year_en;
    logic  month_en;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } sts_t;

  function automatic logic [5:0] pass_divisor(input pass_t p);
    logic [5:0] d;
    unique case (p)
      PASS_SEC:  d = 6'd60;
      PASS_MIN:  d = 6'd60;
      PASS_HOUR: d = 6'd24;
      PASS_WDAY: d = 6'd7;
      default:   d = 6'd60;
    endcase
    return d;
  endfunction

  // Rounded-up reciprocals of the divisors. With the matching right shift
  // (37 for 60, 36 for 24, 34 for 7) the quotient is exact for any dividend
  // below 2^31.
  function automatic logic [DqWidth-1:0] pass_recip(input pass_t p);
    logic [DqWidth-1:0] m;
    case (p)
      PASS_HOUR: m = 32'd2863311531;
      PASS_WDAY: m = 32'd2454267027;
      default:   m = 32'd2290649225;
    endcase
    return m;
  endfunction

  // Common-year month lengths; February is extended by the caller.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] l;
    case (m)
      4'd1:                     l = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:  l = 5'd30;
      default:                  l = 5'd31;
    endcase
    return l;
  endfunction

endpackage

FILE: src/esc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_ctrl
// Sequencer: divider passes, year stepping, month stepping, result handoff.
// ----------------------------------------------------------------------------
module esc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  esc_pkg::sts_t sts,
  output esc_pkg::cmd_t cmd
);
  import esc_pkg::*;

  state_t               state, state_next;
  pass_t                pass, pass_next;
  logic [StepWidth-1:0] step, step_next;
  logic                 out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pass      <= PASS_SEC;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pass      <= pass_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    pass_next      = pass;
    step_next      = step;
    out_valid_next = out_valid;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.pass       = pass;
    cmd.div_first  = (step == '0);
    cmd.div_last   = (step == StepWidth'(DivSteps - 1));

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          pass_next  = PASS_SEC;
          step_next  = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        step_next  = step + 1'b1;
        if (cmd.div_last) begin
          step_next = '0;
          if (pass == PASS_WDAY) begin
            state_next = ST_YEAR;
          end else begin
            pass_next = pass_t'(pass + 1'b1);
          end
        end
      end
      ST_YEAR: begin
        if (sts.year_done) begin
          state_next = ST_MONTH;
        end else begin
          cmd.year_en = 1'b1;
        end
      end
      ST_MONTH: begin
        if (sts.month_done) begin
          state_next = ST_FINISH;
        end else begin
          cmd.month_en = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: src/esc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_datapath
// Reciprocal-multiply constant divider, year and month subtractors, result
// register.
// ----------------------------------------------------------------------------
module esc_datapath (
  input  logic          clk,
  input  esc_pkg::cmd_t cmd,
  output esc_pkg::sts_t sts,
  input  logic [30:0]   epoch_seconds,
  output logic [10:0]   cal_year,
  output logic [3:0]    cal_month,
  output logic [4:0]    day_in_month,
  output logic [2:0]    week_day,
  output logic [4:0]    hour_of_day,
  output logic [5:0]    minute_of_hour,
  output logic [5:0]    second_of_minute
);
  import esc_pkg::*;

  logic [DqWidth-1:0]   dq;
  logic [DqWidth-1:0]   quo;
  logic [DqWidth-1:0]   q_calc;
  logic [DqWidth-1:0]   recip;
  logic [DqWidth-1:0]   qd;
  logic [DqWidth-1:0]   diff;
  logic [2*DqWidth-1:0] prod;
  logic [5:0]           rem_next;
  logic [5:0]           sec_r, min_r;
  logic [4:0]           hour_r;
  logic [2:0]           wday_r;
  logic [3:0]           wday_sum;
  logic [DaysWidth-1:0] days;
  logic [10:0]          year;
  logic [6:0]           mod100;
  logic [8:0]           mod400;
  logic [3:0]           month;
  logic                 leap;
  logic [8:0]           ylen;
  logic [4:0]           mlen;
  logic [5:0]           dvs;

  // In each pass the first step registers the quotient from a multiply by
  // the divisor's reciprocal, and the last step forms the remainder from
  // that registered quotient.
  always_comb begin
    dvs   = pass_divisor(cmd.pass);
    recip = pass_recip(cmd.pass);
    prod  = {{DqWidth{1'b0}}, dq} * {{DqWidth{1'b0}}, recip};
    case (cmd.pass)
      PASS_HOUR: q_calc = {4'd0, prod[63:36]};
      PASS_WDAY: q_calc = {2'd0, prod[63:34]};
      default:   q_calc = {5'd0, prod[63:37]};
    endcase
    qd       = quo * {{(DqWidth-6){1'b0}}, dvs};
    diff     = dq - qd;
    rem_next = diff[5:0];
  end

  assign wday_sum = {1'b0, rem_next[2:0]} + {1'b0, EpochWeekday};

  assign leap = (mod400 == '0) || ((mod100 != '0) && (year[1:0] == 2'd0));
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(month) + {4'd0, (month == MonthFeb) && leap};

  assign sts.year_done  = days < {{(DaysWidth-9){1'b0}}, ylen};
  assign sts.month_done = (month == MonthDec) ||
                          (days < {{(DaysWidth-5){1'b0}}, mlen});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dq     <= {{(DqWidth-SecWidth){1'b0}}, epoch_seconds};
      year   <= EpochYear;
      mod100 <= EpochMod100;
      mod400 <= EpochMod400;
      month  <= '0;
    end
    if (cmd.div_en) begin
      if (cmd.div_first) begin
        quo <= q_calc;
      end
      if (cmd.div_last) begin
        dq <= quo;
        case (cmd.pass)
          PASS_SEC:  sec_r <= rem_next;
          PASS_MIN:  min_r <= rem_next;
          PASS_HOUR: begin
            hour_r <= rem_next[4:0];
            days   <= quo[DaysWidth-1:0];
          end
          default:   wday_r <= (wday_sum >= 4'd7) ? 3'(wday_sum - 4'd7) : wday_sum[2:0];
        endcase
      end
    end
    if (cmd.year_en) begin
      days   <= days - {{(DaysWidth-9){1'b0}}, ylen};
      year   <= year + 11'd1;
      mod100 <= (mod100 == 7'd99)  ? 7'd0 : mod100 + 7'd1;
      mod400 <= (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;
    end
    if (cmd.month_en) begin
      days  <= days - {{(DaysWidth-5){1'b0}}, mlen};
      month <= month + 4'd1;
    end
    if (cmd.out_load) begin
      cal_year         <= year;
      cal_month        <= month;
      day_in_month     <= days[4:0];
      week_day         <= wday_r;
      hour_of_day      <= hour_r;
      minute_of_hour   <= min_r;
      second_of_minute <= sec_r;
    end
  end

endmodule

FILE: src/epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts seconds since 1970-01-01 00:00:00 into Gregorian calendar fields.
// ----------------------------------------------------------------------------
// Usage:
// A request on the input channel (in_valid/in_ready) carries epoch_seconds.
// The block takes one request at a time; in_ready is high only while it is
// idle. Each request produces exactly one result on the output channel
// (out_valid/out_ready) carrying year, month, day of month, weekday, hour,
// minute and second.
// Sequence: four divider passes (by 60, 60, 24 and 7), each a reciprocal
// multiply and then the remainder; year stepping subtracts one year length
// per whole year elapsed, month stepping one month length per whole month
// elapsed in the final year, and a handoff state loads the result register.
// The year stepping loop takes most of the time from the accepting edge to
// a valid result. The block is idle again the cycle after the handoff, so
// it takes a new request only once the previous result has been handed over.
// The result sits in its own output register, so a new request is accepted
// while the previous result still waits; if the receiver stalls, a finished
// conversion waits in the handoff state until the output register frees up.
// Reset clears the sequencer and the output valid flag; no clearing pass.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [30:0] epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] cal_year,
  output logic [3:0]  cal_month,
  output logic [4:0]  day_in_month,
  output logic [2:0]  week_day,
  output logic [4:0]  hour_of_day,
  output logic [5:0]  minute_of_hour,
  output logic [5:0]  second_of_minute
);
  import esc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller owns all sequencing; the datapath only acts on commands.
  esc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  esc_datapath u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .sts              (sts),
    .epoch_seconds    (epoch_seconds),
    .cal_year         (cal_year),
    .cal_month        (cal_month),
    .day_in_month     (day_in_month),
    .week_day         (week_day),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute)
  );

endmodule

FILE: src/esc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_checker
// Port-level checks for the epoch seconds to calendar block.
// ----------------------------------------------------------------------------
module esc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [10:0] cal_year,
  input logic [3:0]  cal_month,
  input logic [4:0]  day_in_month,
  input logic [2:0]  week_day,
  input logic [4:0]  hour_of_day,
  input logic [5:0]  minute_of_hour,
  input logic [5:0]  second_of_minute
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cal_year) && $stable(cal_month) &&
      $stable(day_in_month) && $stable(week_day) && $stable(hour_of_day) &&
      $stable(minute_of_hour) && $stable(second_of_minute))
    else $error("result changed while stalled");

  // One request at a time: busy right after an accept.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cal_month <= 4'd11 && day_in_month <= 5'd30 && week_day <= 3'd6 &&
      hour_of_day <= 5'd23 && minute_of_hour <= 6'd59 && second_of_minute <= 6'd59)
    else $error("calendar field out of range");

  a_year: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cal_year >= 11'd1970 && cal_year <= 11'd2038)
    else $error("year out of range");

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .cal_year         (cal_year),
  .cal_month        (cal_month),
  .day_in_month     (day_in_month),
  .week_day         (week_day),
  .hour_of_day      (hour_of_day),
  .minute_of_hour   (minute_of_hour),
  .second_of_minute (second_of_minute)
);

FILE: verif/calendar_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_checker
// Watches both channels of the epoch seconds to calendar block. It predicts
// the calendar fields of every accepted request and compares each delivered
// result with the oldest prediction.
// ----------------------------------------------------------------------------
module calendar_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [30:0] epoch_seconds,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [10:0] cal_year,
  input  logic [3:0]  cal_month,
  input  logic [4:0]  day_in_month,
  input  logic [2:0]  week_day,
  input  logic [4:0]  hour_of_day,
  input  logic [5:0]  minute_of_hour,
  input  logic [5:0]  second_of_minute,
  output int          mismatches,
  output int          pending,
  output int          results_seen
);

  import esc_pkg::*;

  localparam int unsigned SecsPerMinute = 60;
  localparam int unsigned SecsPerHour   = 3600;
  localparam int unsigned SecsPerDay    = 86400;
  localparam int unsigned HoursPerDay   = 24;
  localparam int unsigned DaysPerWeek   = 7;

  typedef struct packed {
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [2:0]  wday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  calendar_t dates_due [$];
  int        requests_seen;

  assign pending = requests_seen - results_seen;

  function automatic bit is_leap_year(input int unsigned y);
    if (y % 400 == 0) return 1'b1;
    if (y % 100 == 0) return 1'b0;
    return (y % 4 == 0);
  endfunction

  function automatic calendar_t to_calendar(input logic [30:0] secs);
    calendar_t   c;
    int unsigned total;
    int unsigned days;
    int unsigned year;
    int unsigned month;
    int unsigned ylen;
    int unsigned mlen;
    bit          leap;
    total    = {1'b0, secs};
    days     = total / SecsPerDay;
    c.hour   = 5'((total / SecsPerHour) % HoursPerDay);
    c.minute = 6'((total / SecsPerMinute) % SecsPerMinute);
    c.second = 6'(total % SecsPerMinute);
    c.wday   = 3'((EpochWeekday + days % DaysPerWeek) % DaysPerWeek);

    // Strip whole years, then whole months of the year that remains.
    year = {21'd0, EpochYear};
    ylen = is_leap_year(year) ? 366 : 365;
    while (days >= ylen) begin
      days -= ylen;
      year++;
      ylen = is_leap_year(year) ? 366 : 365;
    end
    leap  = is_leap_year(year);
    month = 0;
    while (month < MonthDec) begin
      case (month)
        MonthFeb:    mlen = leap ? 29 : 28;
        3, 5, 8, 10: mlen = 30;
        default:     mlen = 31;
      endcase
      if (days < mlen) break;
      days -= mlen;
      month++;
    end
    c.year  = 11'(year);
    c.month = 4'(month);
    c.mday  = 5'(days);
    return c;
  endfunction

  always @(posedge clk) begin
    calendar_t want;
    calendar_t got;
    if (rst) begin
      dates_due.delete();
      requests_seen <= 0;
      results_seen  <= 0;
      mismatches    <= 0;
    end else begin
      // Results are handled before new requests: a result can never belong
      // to a request accepted at the same edge.
      if (out_valid && out_ready) begin
        got = '{cal_year, cal_month, day_in_month, week_day, hour_of_day,
                minute_of_hour, second_of_minute};
        results_seen <= results_seen + 1;
        if (dates_due.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] result with no request pending: %0d-%0d-%0d", $realtime,
                     got.year, got.month, got.mday);
          mismatches <= mismatches + 1;
        end else begin
          want = dates_due.pop_front();
          if (got.year !== want.year || got.month !== want.month ||
              got.mday !== want.mday || got.wday !== want.wday ||
              got.hour !== want.hour || got.minute !== want.minute ||
              got.second !== want.second) begin
            if (mismatches < 10) begin
              $display("[%0t] mismatch: expected %0d/%0d/%0d wd%0d %0d:%0d:%0d",
                       $realtime, want.year, want.month, want.mday, want.wday,
                       want.hour, want.minute, want.second);
              $display("[%0t]           got      %0d/%0d/%0d wd%0d %0d:%0d:%0d",
                       $realtime, got.year, got.month, got.mday, got.wday,
                       got.hour, got.minute, got.second);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        dates_due.push_back(to_calendar(epoch_seconds));
        requests_seen <= requests_seen + 1;
      end
    end
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives timestamps into the epoch seconds to calendar block and reports the
// verdict. A directed set covers field extremes and calendar edges (year
// ends, leap days, the century leap year 2000, the last representable
// second); random timestamps follow, with random sender gaps and receiver
// stalls. Results are compared with predictions in the calendar checker.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CycleLimit    = 600000;
  localparam int RandomCount   = 700;
  localparam int CalmTail      = 80;   // final requests run without any idling
  localparam int DrainAt       = 350;  // random request index of the full drain
  localparam int SettleCycles  = 150;  // above the worst-case latency
  localparam int CornerCount   = 21;
  localparam int unsigned LastDay = 24854;  // last whole day below 2^31 s

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [30:0] epoch_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [10:0] cal_year;
  logic [3:0]  cal_month;
  logic [4:0]  day_in_month;
  logic [2:0]  week_day;
  logic [4:0]  hour_of_day;
  logic [5:0]  minute_of_hour;
  logic [5:0]  second_of_minute;

  int mismatches;
  int pending;
  int results_seen;
  int cycle_count;
  int requests_sent;
  int stall_left;
  bit tx_gaps_on;
  bit rx_stalls_on;

  int unsigned corner_secs [CornerCount];

  epoch_seconds_to_calendar dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .epoch_seconds    (epoch_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .cal_year         (cal_year),
    .cal_month        (cal_month),
    .day_in_month     (day_in_month),
    .week_day         (week_day),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute)
  );

  calendar_checker u_calendar_check (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .epoch_seconds    (epoch_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .cal_year         (cal_year),
    .cal_month        (cal_month),
    .day_in_month     (day_in_month),
    .week_day         (week_day),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute),
    .mismatches       (mismatches),
    .pending          (pending),
    .results_seen     (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // A hung handshake would otherwise run forever, so the cycle count caps
  // the run far above the slowest legal schedule.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles with %0d results pending", cycle_count, pending);
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver drops out_ready in bursts of random length while stalls
  // are enabled, and keeps it high otherwise.
  always @(posedge clk) begin
    if (rst || !rx_stalls_on) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Puts one request on the input channel and returns at the edge that
  // accepts it. in_valid is left high so that a back-to-back request can
  // follow without in_valid dropping in between.
  task automatic send_request(input logic [30:0] secs);
    in_valid      <= 1'b1;
    epoch_seconds <= secs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic hold_off(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops sending until the block has delivered every result owed.
  task automatic drain_results;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly uniform times, with a good share landing on day boundaries (so
  // year and month rollovers appear often), near the top of the range, near
  // the epoch, or on a single set or cleared bit.
  function automatic logic [30:0] random_seconds;
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom;
      5, 6: v = $urandom_range(0, LastDay) * 86400 + ($urandom_range(0, 1) ? 0 : 86399);
      7: v = 32'h7FFF_FFFF - $urandom_range(0, 100000);
      8: v = $urandom_range(0, 4000000);
      default: begin
        v = 32'h1 << $urandom_range(0, 30);
        if ($urandom_range(0, 1)) v = ~v;
      end
    endcase
    return v[30:0];
  endfunction

  initial begin
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    // Field extremes and calendar edges: the epoch, minute/hour/day
    // rollovers, the end of February and of 1970, the leap day of 1972 and
    // the end of that leap year, the turn of 2000 with its century leap day,
    // the last second the input can hold, and alternating bit patterns.
    corner_secs = '{0, 59, 60, 3599, 3600, 86399, 86400, 5097599, 5097600,
                    31535999, 31536000, 68169600, 68255999, 94694399,
                    946684799, 951782400, 951868799, 978307199, 2147483647,
                    1431655765, 715827882};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed requests go back to back with the receiver always ready.
    foreach (corner_secs[i]) send_request(corner_secs[i][30:0]);
    drain_results();

    for (int n = 0; n < RandomCount; n++) begin
      // Idling changes character every 40 requests, so there are stretches
      // with gaps, with stalls, with both and with neither.
      if (n % 40 == 0) begin
        tx_gaps_on   = ($urandom_range(0, 3) != 0);
        rx_stalls_on = ($urandom_range(0, 3) != 0);
      end
      if (n >= RandomCount - CalmTail) begin
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
      end
      if (n == DrainAt) drain_results();
      if (tx_gaps_on && $urandom_range(0, 2) == 0) hold_off($urandom_range(1, 5));
      send_request(random_seconds());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Converted %0d timestamps (%0d directed calendar edges, rest random),",
             requests_sent, CornerCount);
    $display("checked %0d results under random sender gaps and receiver stalls.",
             results_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
